### rtl/c8_pkg.sv
// Shared types, constants and font table for the CHIP-8 instruction core.
package c8_pkg;

    localparam int MEMORY_BYTES  = 4096;
    localparam int STACK_DEPTH   = 16;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ADDR_W        = 12;
    localparam int ROW_W         = 5;
    localparam int FONT_BYTES    = 80;

    localparam logic [11:0] PROGRAM_START = 12'h200;
    localparam logic [11:0] FONT_BASE     = 12'h050;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_RUN  = 2'd1,
        CMD_ROW  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [11:0] program_address;
        logic [15:0] executed_opcode;
        logic [7:0]  flag_value;
        logic [63:0] row_pixels;
        logic        awaiting_key;
        logic        tone_active;
    } result_t;

    // Memory port request from the sequencer to the memory unit.
    typedef struct packed {
        logic        we;
        logic [11:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    function automatic logic [7:0] font_byte(input logic [6:0] i);
        logic [7:0] f;
        unique case (i)
            7'd0: f = 8'hF0;  7'd1: f = 8'h90;  7'd2: f = 8'h90;  7'd3: f = 8'h90;
            7'd4: f = 8'hF0;  7'd5: f = 8'h20;  7'd6: f = 8'h60;  7'd7: f = 8'h20;
            7'd8: f = 8'h20;  7'd9: f = 8'h70;  7'd10: f = 8'hF0; 7'd11: f = 8'h10;
            7'd12: f = 8'hF0; 7'd13: f = 8'h80; 7'd14: f = 8'hF0; 7'd15: f = 8'hF0;
            7'd16: f = 8'h10; 7'd17: f = 8'hF0; 7'd18: f = 8'h10; 7'd19: f = 8'hF0;
            7'd20: f = 8'h90; 7'd21: f = 8'h90; 7'd22: f = 8'hF0; 7'd23: f = 8'h10;
            7'd24: f = 8'h10; 7'd25: f = 8'hF0; 7'd26: f = 8'h80; 7'd27: f = 8'hF0;
            7'd28: f = 8'h10; 7'd29: f = 8'hF0; 7'd30: f = 8'hF0; 7'd31: f = 8'h80;
            7'd32: f = 8'hF0; 7'd33: f = 8'h90; 7'd34: f = 8'hF0; 7'd35: f = 8'hF0;
            7'd36: f = 8'h10; 7'd37: f = 8'h20; 7'd38: f = 8'h40; 7'd39: f = 8'h40;
            7'd40: f = 8'hF0; 7'd41: f = 8'h90; 7'd42: f = 8'hF0; 7'd43: f = 8'h90;
            7'd44: f = 8'hF0; 7'd45: f = 8'hF0; 7'd46: f = 8'h90; 7'd47: f = 8'hF0;
            7'd48: f = 8'h10; 7'd49: f = 8'hF0; 7'd50: f = 8'hF0; 7'd51: f = 8'h90;
            7'd52: f = 8'hF0; 7'd53: f = 8'h90; 7'd54: f = 8'h90; 7'd55: f = 8'hE0;
            7'd56: f = 8'h90; 7'd57: f = 8'hE0; 7'd58: f = 8'h90; 7'd59: f = 8'hE0;
            7'd60: f = 8'hF0; 7'd61: f = 8'h80; 7'd62: f = 8'h80; 7'd63: f = 8'h80;
            7'd64: f = 8'hF0; 7'd65: f = 8'hE0; 7'd66: f = 8'h90; 7'd67: f = 8'h90;
            7'd68: f = 8'h90; 7'd69: f = 8'hE0; 7'd70: f = 8'hF0; 7'd71: f = 8'h80;
            7'd72: f = 8'hF0; 7'd73: f = 8'h80; 7'd74: f = 8'hF0; 7'd75: f = 8'hF0;
            7'd76: f = 8'h80; 7'd77: f = 8'hF0; 7'd78: f = 8'h80; 7'd79: f = 8'h80;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

endpackage

### rtl/chip8_instruction_core_unit.sv
// Top level of the CHIP-8 instruction core: stream ports, sequencer, memories, output register.
//  channel | dir | tdata fields (low to high)                               | tuser
//  s_      | in  | load_address, load_data, keys_down, random_value, row_sel | command
//  m_      | out | program_address, executed_opcode, flag_value, row_pixels, | -
//          |     | awaiting_key, tone_active                                 |
// An instruction fetches and executes; a sprite draw adds a read/modify/write pass per row,
// Fx55 a pass per byte, Fx65 a read pass and a load pass per byte, Fx33 a digit loop.
// The single memory port and the framebuffer row port make these passes necessary.
// After reset a clearing pass over all 4096 bytes loads the font; s_tready stays low.
// One item at a time; the output register holds a result until m_tready.
module chip8_instruction_core_unit
    import c8_pkg::*;
#(
    parameter int STACK_DEPTH_P = STACK_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,  // load_address, load_data, keys_down, random_value, row_select,
                                   // zero fill
    input  logic [1:0]   s_tuser,  // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata   // program_address, executed_opcode, flag_value, row_pixels,
                                   // awaiting_key, tone_active, zero fill
);
    mem_req_t    mreq;
    logic [7:0]  mrdata;
    logic        init_done;
    logic [4:0]  fb_addr;
    logic        fb_we, fb_clear;
    logic [63:0] fb_wdata, fb_rdata;
    logic        busy, done;
    result_t     res;
    logic        ov_reg, ov_next;
    result_t     out_reg;
    logic        start;

    assign s_tready = init_done && !busy && !ov_reg;
    assign start = s_tvalid && s_tready;

    c8_mem u_mem (
        .aclk(aclk), .aresetn(aresetn), .req(mreq), .rdata(mrdata), .init_done(init_done)
    );

    c8_fb u_fb (
        .aclk(aclk), .aresetn(aresetn), .addr(fb_addr), .we(fb_we), .wdata(fb_wdata),
        .clear_all(fb_clear), .rdata(fb_rdata)
    );

    c8_seq #(.STACK_DEPTH_P(STACK_DEPTH_P)) u_seq (
        .aclk(aclk), .aresetn(aresetn), .start(start), .cmd(s_tuser),
        .load_address(s_tdata[11:0]), .load_data(s_tdata[19:12]),
        .keys(s_tdata[35:20]), .rnd(s_tdata[43:36]), .row_sel(s_tdata[48:44]),
        .busy(busy), .done(done), .result(res), .mreq(mreq), .mrdata(mrdata),
        .fb_addr(fb_addr), .fb_we(fb_we), .fb_wdata(fb_wdata), .fb_clear(fb_clear),
        .fb_rdata(fb_rdata)
    );

    always_comb begin
        ov_next = ov_reg;
        if (done) ov_next = 1'b1;
        else if (m_tready) ov_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) ov_reg <= 1'b0;
        else ov_reg <= ov_next;
    end

    always_ff @(posedge aclk) begin
        if (done) out_reg <= res;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = {2'b00, out_reg.tone_active, out_reg.awaiting_key, out_reg.row_pixels,
                      out_reg.flag_value, out_reg.executed_opcode, out_reg.program_address};

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy) else $error("accepted item did not start work");
    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !ov_reg) else $error("result overwritten");
    a_ready_init: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_tready) else $error("accept during memory clear");
endmodule

### rtl/c8_mem.sv
// Main memory: one read/write port, registered read, clearing pass with font after reset.
module c8_mem
    import c8_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mem_req_t req,
    output logic [7:0] rdata,
    output logic     init_done
);
    logic [7:0]  mem [MEMORY_BYTES];
    logic [ADDR_W:0] clr_reg, clr_next;
    logic        done_reg, done_next;
    logic [11:0] clr_addr;
    logic [11:0] font_off;
    logic [7:0]  clr_data;

    assign clr_addr = clr_reg[ADDR_W-1:0];
    assign font_off = clr_addr - FONT_BASE;
    always_comb begin
        clr_data = 8'h00;
        if (clr_addr >= FONT_BASE && clr_addr < FONT_BASE + 12'(FONT_BYTES)) begin
            clr_data = font_byte(font_off[6:0]);
        end
        clr_next = clr_reg + 1'b1;
        done_next = done_reg | (clr_reg == (ADDR_W+1)'(MEMORY_BYTES - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end else if (!done_reg) begin
            clr_reg  <= clr_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!done_reg) begin
            mem[clr_addr] <= clr_data;
        end else if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

    assign init_done = done_reg;
endmodule

### rtl/c8_fb.sv
// Framebuffer: 32 rows of 64 pixels, one row read or written per cycle, valid bits per row.
module c8_fb
    import c8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [4:0]  addr,
    input  logic        we,
    input  logic [63:0] wdata,
    input  logic        clear_all,
    output logic [63:0] rdata
);
    logic [63:0] rows [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] valid_reg, valid_next;
    logic [63:0] raw;
    logic        rvalid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (clear_all) valid_next = '0;
        else if (we) valid_next[addr] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= '0;
        else valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (we && !clear_all) rows[addr] <= wdata;
        raw <= rows[addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) rvalid_reg <= 1'b0;
        else rvalid_reg <= valid_reg[addr] && !clear_all;
    end

    assign rdata = rvalid_reg ? raw : 64'd0;
endmodule

### rtl/c8_seq.sv
// Sequencer: fetch, decode and execute as a state machine using the memory port and framebuffer row port.
module c8_seq
    import c8_pkg::*;
#(
    parameter int STACK_DEPTH_P = STACK_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [1:0]  cmd,
    input  logic [11:0] load_address,
    input  logic [7:0]  load_data,
    input  logic [15:0] keys,
    input  logic [7:0]  rnd,
    input  logic [4:0]  row_sel,
    output logic        busy,
    output logic        done,
    output result_t     result,
    output mem_req_t    mreq,
    input  logic [7:0]  mrdata,
    output logic [4:0]  fb_addr,
    output logic        fb_we,
    output logic [63:0] fb_wdata,
    output logic        fb_clear,
    input  logic [63:0] fb_rdata
);
    localparam int SP_W = $clog2(STACK_DEPTH_P);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_F0    = 12'b000000000010,
        S_F1    = 12'b000000000100,
        S_F2    = 12'b000000001000,
        S_EXEC  = 12'b000000010000,
        S_DRD   = 12'b000000100000,
        S_DWAIT = 12'b000001000000,
        S_DROW  = 12'b000010000000,
        S_MOVE  = 12'b000100000000,
        S_BCD   = 12'b001000000000,
        S_ROW   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    state_t      st_reg, st_next;
    logic [7:0]  v_reg [16];
    logic [7:0]  v_next [16];
    logic [15:0] i_reg, i_next;
    logic [11:0] pc_reg, pc_next;
    logic [11:0] stk [STACK_DEPTH_P];
    logic        stk_we;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next, st_cnt_reg, st_cnt_next;
    logic [15:0] op_reg, op_next;
    logic [15:0] keys_reg, keys_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [4:0]  rsel_reg, rsel_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  tmp_reg, tmp_next;
    logic [7:0]  dig_reg, dig_next;
    logic        wait_reg, wait_next;
    logic [63:0] row_reg, row_next;

    logic [3:0]  ox, oy, on;
    logic [7:0]  okk, vx, vy;
    logic [11:0] nnn;
    logic [11:0] pc2;
    logic [15:0] ia;
    logic [8:0]  sum;
    logic [8:0]  dxy, dyx;
    logic [5:0]  xs;
    logic [4:0]  ys;
    logic [5:0]  py;
    logic [70:0] spr;
    logic [63:0] mask;
    logic        key_hit;
    logic [3:0]  first_key;
    logic        any_key;

    assign ox  = op_reg[11:8];
    assign oy  = op_reg[7:4];
    assign on  = op_reg[3:0];
    assign okk = op_reg[7:0];
    assign nnn = op_reg[11:0];
    assign vx  = v_reg[ox];
    assign vy  = v_reg[oy];
    assign pc2 = pc_reg + 12'd2;
    assign ia  = i_reg + 16'(cnt_reg);
    assign sum = {1'b0, vx} + {1'b0, vy};
    assign dxy = {1'b0, vx} - {1'b0, vy};
    assign dyx = {1'b0, vy} - {1'b0, vx};
    assign xs  = vx[5:0];
    assign ys  = vy[4:0];
    assign py  = {1'b0, ys} + {2'b00, cnt_reg};
    assign spr = {tmp_reg, 63'd0} >> xs;
    assign mask = spr[70:7];
    assign key_hit = (vx < 8'd16) && keys_reg[vx[3:0]];

    always_comb begin
        any_key = 1'b0;
        first_key = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (keys_reg[k]) begin
                any_key = 1'b1;
                first_key = 4'(k);
            end
        end
    end

    always_comb begin
        st_next = st_reg;
        for (int k = 0; k < 16; k++) v_next[k] = v_reg[k];
        i_next = i_reg; pc_next = pc_reg; sp_next = sp_reg;
        dt_next = dt_reg; st_cnt_next = st_cnt_reg; op_next = op_reg;
        keys_next = keys_reg; rnd_next = rnd_reg; rsel_next = rsel_reg;
        cmd_next = cmd_reg; cnt_next = cnt_reg; tmp_next = tmp_reg;
        dig_next = dig_reg; wait_next = wait_reg; row_next = row_reg;
        stk_we = 1'b0;
        mreq = '{we: 1'b0, addr: pc_reg, wdata: 8'h00};
        fb_addr = rsel_reg; fb_we = 1'b0; fb_wdata = 64'd0; fb_clear = 1'b0;

        unique case (st_reg)
            S_IDLE: begin
                if (start) begin
                    cmd_next = cmd; keys_next = keys; rnd_next = rnd;
                    rsel_next = row_sel;
                    wait_next = 1'b0; row_next = 64'd0; cnt_next = 4'd0;
                    unique case (cmd_t'(cmd))
                        CMD_RUN:  st_next = S_F0;
                        CMD_ROW:  st_next = S_ROW;
                        CMD_LOAD: st_next = S_DONE;
                        CMD_NONE: st_next = S_DONE;
                    endcase
                    if (cmd_t'(cmd) == CMD_LOAD) begin
                        mreq = '{we: 1'b1, addr: load_address, wdata: load_data};
                    end
                    mreq.addr = (cmd_t'(cmd) == CMD_RUN) ? pc_reg : load_address;
                end
            end
            S_F0: begin
                mreq.addr = pc_reg + 12'd1;
                op_next[15:8] = mrdata;
                st_next = S_F1;
            end
            S_F1: begin
                op_next[7:0] = mrdata;
                st_next = S_F2;
            end
            S_F2: begin
                pc_next = pc2;
                st_next = S_EXEC;
            end
            S_EXEC: begin
                st_next = S_DONE;
                unique case (op_reg[15:12])
                    4'h0: begin
                        if (op_reg == 16'h00E0) fb_clear = 1'b1;
                        else if (op_reg == 16'h00EE) begin
                            sp_next = (sp_reg == '0) ? SP_W'(STACK_DEPTH_P - 1)
                                                     : sp_reg - 1'b1;
                            pc_next = stk[sp_next];
                        end
                    end
                    4'h1: pc_next = nnn;
                    4'h2: begin
                        stk_we = 1'b1;
                        sp_next = (sp_reg == SP_W'(STACK_DEPTH_P - 1)) ? '0 : sp_reg + 1'b1;
                        pc_next = nnn;
                    end
                    4'h3: if (vx == okk) pc_next = pc_reg + 12'd2;
                    4'h4: if (vx != okk) pc_next = pc_reg + 12'd2;
                    4'h5: if (vx == vy) pc_next = pc_reg + 12'd2;
                    4'h6: v_next[ox] = okk;
                    4'h7: v_next[ox] = vx + okk;
                    4'h8: begin
                        unique case (on)
                            4'h0: v_next[ox] = vy;
                            4'h1: v_next[ox] = vx | vy;
                            4'h2: v_next[ox] = vx & vy;
                            4'h3: v_next[ox] = vx ^ vy;
                            4'h4: begin v_next[15] = {7'd0, sum[8]}; v_next[ox] = sum[7:0]; end
                            4'h5: begin v_next[15] = {7'd0, vx > vy}; v_next[ox] = dxy[7:0]; end
                            4'h6: begin v_next[15] = {7'd0, vx[0]}; v_next[ox] = vx >> 1; end
                            4'h7: begin v_next[15] = {7'd0, vy > vx}; v_next[ox] = dyx[7:0]; end
                            4'hE: begin v_next[15] = {7'd0, vx[7]}; v_next[ox] = vx << 1; end
                            default: ;
                        endcase
                    end
                    4'h9: if (vx != vy) pc_next = pc_reg + 12'd2;
                    4'hA: i_next = {4'd0, nnn};
                    4'hB: pc_next = nnn + {4'd0, v_reg[0]};
                    4'hC: v_next[ox] = rnd_reg & okk;
                    4'hD: begin
                        cnt_next = 4'd0;
                        dig_next = 8'd0;
                        if (on != 4'd0) begin
                            st_next = S_DRD;
                        end else v_next[15] = 8'd0;
                    end
                    4'hE: begin
                        if (okk == 8'h9E && key_hit) pc_next = pc_reg + 12'd2;
                        else if (okk == 8'hA1 && !key_hit) pc_next = pc_reg + 12'd2;
                    end
                    4'hF: begin
                        unique case (okk)
                            8'h07: v_next[ox] = dt_reg;
                            8'h0A: begin
                                if (any_key) v_next[ox] = {4'd0, first_key};
                                else begin pc_next = pc_reg - 12'd2; wait_next = 1'b1; end
                            end
                            8'h15: dt_next = vx;
                            8'h18: st_cnt_next = vx;
                            8'h1E: i_next = i_reg + {8'd0, vx};
                            8'h29: i_next = 16'(FONT_BASE) + ({8'd0, vx} << 2) + {8'd0, vx};
                            8'h33: begin
                                tmp_next = vx; dig_next = 8'd0; cnt_next = 4'd0;
                                st_next = S_BCD;
                            end
                            8'h55, 8'h65: begin
                                cnt_next = 4'd0; tmp_next = 8'd0; st_next = S_MOVE;
                                mreq.addr = ia[11:0];
                            end
                            default: ;
                        endcase
                    end
                endcase
                if (st_next == S_DONE) begin
                    if (dt_next != 8'd0 && !(op_reg[15:12] == 4'hF && okk == 8'h15))
                        dt_next = dt_next - 1'b1;
                    else if (op_reg[15:12] == 4'hF && okk == 8'h15 && dt_next != 8'd0)
                        dt_next = dt_next - 1'b1;
                    if (st_cnt_next != 8'd0) st_cnt_next = st_cnt_next - 1'b1;
                end
            end
            // Sprite: issue byte read, then row read/modify/write; VF written at the end.
            S_DRD: begin
                mreq.addr = ia[11:0];
                st_next = S_DWAIT;
            end
            S_DWAIT: begin
                fb_addr = py[4:0];
                tmp_next = mrdata;
                st_next = S_DROW;
            end
            S_DROW: begin
                fb_addr = py[4:0];
                if (!py[5]) begin
                    fb_we = 1'b1;
                    fb_wdata = fb_rdata ^ mask;
                    if ((fb_rdata & mask) != 64'd0) dig_next = 8'd1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == on - 4'd1) begin
                    st_next = S_DONE;
                    v_next[15] = {7'd0, dig_next[0]};
                    if (dt_reg != 8'd0) dt_next = dt_reg - 1'b1;
                    if (st_cnt_reg != 8'd0) st_cnt_next = st_cnt_reg - 1'b1;
                end else st_next = S_DRD;
            end
            // Block move: Fx55 writes a byte per pass; Fx65 reads, then loads from registered data.
            S_MOVE: begin
                mreq.addr = ia[11:0];
                if (okk == 8'h55) begin
                    mreq.we = 1'b1;
                    mreq.wdata = v_reg[cnt_reg];
                    tmp_next = 8'd0;
                end
                if (okk == 8'h65 && tmp_reg[0]) begin
                    v_next[cnt_reg] = mrdata;
                    tmp_next = 8'd0;
                    cnt_next = cnt_reg + 1'b1;
                end else if (okk == 8'h65) begin
                    tmp_next = 8'd1;
                end else cnt_next = cnt_reg + 1'b1;
                if ((okk == 8'h55 || tmp_reg[0]) && cnt_reg == ox) begin
                    st_next = S_DONE;
                    if (dt_reg != 8'd0) dt_next = dt_reg - 1'b1;
                    if (st_cnt_reg != 8'd0) st_cnt_next = st_cnt_reg - 1'b1;
                end
            end
            // BCD by repeated subtraction of 100 and then of 10, writing the hundreds, tens and ones digits.
            S_BCD: begin
                mreq.addr = ia[11:0];
                if (cnt_reg == 4'd0 && tmp_reg >= 8'd100) begin
                    tmp_next = tmp_reg - 8'd100; dig_next = dig_reg + 1'b1;
                end else if (cnt_reg == 4'd1 && tmp_reg >= 8'd10) begin
                    tmp_next = tmp_reg - 8'd10; dig_next = dig_reg + 1'b1;
                end else begin
                    mreq.we = 1'b1;
                    mreq.wdata = (cnt_reg == 4'd2) ? tmp_reg : dig_reg;
                    dig_next = 8'd0;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 4'd2) begin
                        st_next = S_DONE;
                        if (dt_reg != 8'd0) dt_next = dt_reg - 1'b1;
                        if (st_cnt_reg != 8'd0) st_cnt_next = st_cnt_reg - 1'b1;
                    end
                end
            end
            S_ROW: begin
                fb_addr = rsel_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd1) begin
                    row_next = fb_rdata;
                    st_next = S_DONE;
                end
            end
            S_DONE: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stk_we) stk[sp_reg] <= pc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            for (int k = 0; k < 16; k++) v_reg[k] <= 8'd0;
            i_reg <= '0; pc_reg <= PROGRAM_START; sp_reg <= '0;
            dt_reg <= '0; st_cnt_reg <= '0; op_reg <= '0;
            cmd_reg <= '0; cnt_reg <= '0; wait_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            for (int k = 0; k < 16; k++) v_reg[k] <= v_next[k];
            i_reg <= i_next; pc_reg <= pc_next; sp_reg <= sp_next;
            dt_reg <= dt_next; st_cnt_reg <= st_cnt_next; op_reg <= op_next;
            cmd_reg <= cmd_next; cnt_reg <= cnt_next; wait_reg <= wait_next;
        end
    end

    always_ff @(posedge aclk) begin
        keys_reg <= keys_next; rnd_reg <= rnd_next; rsel_reg <= rsel_next;
        tmp_reg <= tmp_next; dig_reg <= dig_next; row_reg <= row_next;
    end

    assign busy = (st_reg != S_IDLE);
    assign done = (st_reg == S_DONE);
    always_comb begin
        result.program_address = pc_reg;
        result.executed_opcode = (cmd_t'(cmd_reg) == CMD_RUN) ? op_reg : 16'd0;
        result.flag_value      = v_reg[15];
        result.row_pixels      = row_reg;
        result.awaiting_key    = wait_reg;
        result.tone_active     = (st_cnt_reg != 8'd0);
    end
endmodule

### test/chip8_instruction_core_unit_tb.sv
// Self-checking testbench for the CHIP-8 instruction core: random programs against a shadow model.
import c8_pkg::*;

class chip8_shadow;
    logic [7:0]  mem [MEMORY_BYTES];
    logic [7:0]  v [16];
    logic [15:0] idx;
    logic [11:0] pc;
    logic [11:0] stk [16];
    bit          stk_set [16];
    logic [3:0]  sp;
    logic [7:0]  dt, st;
    logic [63:0] fb [SCREEN_HEIGHT];
    result_t     pending [$];
    int          errors, runs, loads, rows, waits, draws;

    function new();
        for (int i = 0; i < MEMORY_BYTES; i++) mem[i] = 8'h00;
        for (int i = 0; i < FONT_BYTES; i++) mem[FONT_BASE + i] = font_byte(7'(i));
        for (int i = 0; i < 16; i++) begin
            v[i] = 8'h00;
            stk_set[i] = 0;
        end
        for (int i = 0; i < SCREEN_HEIGHT; i++) fb[i] = '0;
        idx = '0; pc = PROGRAM_START; sp = '0; dt = '0; st = '0;
    endfunction

    function logic [15:0] opcode_at(logic [11:0] a);
        return {mem[a], mem[12'(a + 1)]};
    endfunction

    // a return would pop an entry that no call ever pushed
    function bit bad_return();
        return opcode_at(pc) == 16'h00EE && !stk_set[4'(sp - 1)];
    endfunction

    function void skip_if(bit c);
        if (c) pc = pc + 12'd2;
    endfunction

    function bit execute(logic [15:0] keys, logic [7:0] rnd);
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  kk, a, b;
        logic [11:0] nnn, adr;
        logic [8:0]  sum;
        logic [7:0]  bits;
        int          px, py, k;
        bit          waiting;
        op = opcode_at(pc);
        waiting = 0;
        pc = pc + 12'd2;
        x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0]; nnn = op[11:0];
        a = v[x]; b = v[y];
        case (op[15:12])
            4'h0: begin
                if (op == 16'h00E0) begin
                    for (int i = 0; i < SCREEN_HEIGHT; i++) fb[i] = '0;
                end else if (op == 16'h00EE) begin
                    sp = sp - 4'd1;
                    pc = stk[sp];
                end
            end
            4'h1: pc = nnn;
            4'h2: begin
                stk[sp] = pc;
                stk_set[sp] = 1;
                sp = sp + 4'd1;
                pc = nnn;
            end
            4'h3: skip_if(a == kk);
            4'h4: skip_if(a != kk);
            4'h5: skip_if(a == b);
            4'h6: v[x] = kk;
            4'h7: v[x] = a + kk;
            4'h8: begin
                case (n)
                    4'h0: v[x] = b;
                    4'h1: v[x] = a | b;
                    4'h2: v[x] = a & b;
                    4'h3: v[x] = a ^ b;
                    4'h4: begin
                        sum = a + b;
                        v[15] = {7'd0, sum[8]};
                        v[x] = sum[7:0];
                    end
                    4'h5: begin v[15] = {7'd0, a > b}; v[x] = a - b; end
                    4'h6: begin v[15] = {7'd0, a[0]}; v[x] = a >> 1; end
                    4'h7: begin v[15] = {7'd0, b > a}; v[x] = b - a; end
                    4'hE: begin v[15] = {7'd0, a[7]}; v[x] = a << 1; end
                    default: ;
                endcase
            end
            4'h9: skip_if(a != b);
            4'hA: idx = {4'd0, nnn};
            4'hB: pc = nnn + {4'd0, v[0]};
            4'hC: v[x] = rnd & kk;
            4'hD: begin
                draws++;
                v[15] = 8'd0;
                for (int r = 0; r < n; r++) begin
                    adr = 12'(idx + r);
                    bits = mem[adr];
                    py = (b % SCREEN_HEIGHT) + r;
                    if (py < SCREEN_HEIGHT) begin
                        for (int c = 0; c < 8; c++) begin
                            px = (a % SCREEN_WIDTH) + c;
                            if (px < SCREEN_WIDTH && bits[7 - c]) begin
                                if (fb[py][63 - px]) v[15] = 8'd1;
                                fb[py][63 - px] = ~fb[py][63 - px];
                            end
                        end
                    end
                end
            end
            4'hE: begin
                if (kk == 8'h9E) skip_if(a < 16 && keys[a[3:0]]);
                else if (kk == 8'hA1) skip_if(!(a < 16 && keys[a[3:0]]));
            end
            default: begin
                case (kk)
                    8'h07: v[x] = dt;
                    8'h0A: begin
                        k = -1;
                        for (int i = 15; i >= 0; i--) if (keys[i]) k = i;
                        if (k >= 0) begin
                            v[x] = 8'(k);
                        end else begin
                            pc = pc - 12'd2;
                            waiting = 1;
                            waits++;
                        end
                    end
                    8'h15: dt = a;
                    8'h18: st = a;
                    8'h1E: idx = idx + {8'd0, a};
                    8'h29: idx = 16'(FONT_BASE) + 16'd5 * {8'd0, a};
                    8'h33: begin
                        mem[idx[11:0]] = a / 100;
                        mem[12'(idx + 1)] = (a / 10) % 10;
                        mem[12'(idx + 2)] = a % 10;
                    end
                    8'h55: for (int i = 0; i <= x; i++) mem[12'(idx + i)] = v[i];
                    8'h65: for (int i = 0; i <= x; i++) v[i] = mem[12'(idx + i)];
                    default: ;
                endcase
            end
        endcase
        if (dt != 0) dt = dt - 8'd1;
        if (st != 0) st = st - 8'd1;
        return waiting;
    endfunction

    function void note(logic [1:0] cmd, logic [48:0] d);
        result_t e;
        e = '0;
        case (cmd_t'(cmd))
            CMD_LOAD: begin
                mem[d[11:0]] = d[19:12];
                loads++;
            end
            CMD_RUN: begin
                e.executed_opcode = opcode_at(pc);
                e.awaiting_key = execute(d[35:20], d[43:36]);
                runs++;
            end
            CMD_ROW: begin
                e.row_pixels = fb[d[48:44]];
                rows++;
            end
            default: ;
        endcase
        e.program_address = pc;
        e.flag_value = v[15];
        e.tone_active = st != 0;
        pending.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    task check(logic [103:0] t);
        result_t e;
        if (pending.size() == 0) begin
            report("unexpected transfer", t[63:0], 64'd0);
        end else begin
            e = pending.pop_front();
            if (t[11:0] !== e.program_address) report("program_address", t[11:0], e.program_address);
            if (t[27:12] !== e.executed_opcode)
                report("executed_opcode", t[27:12], e.executed_opcode);
            if (t[35:28] !== e.flag_value) report("flag_value", t[35:28], e.flag_value);
            if (t[99:36] !== e.row_pixels) report("row_pixels", t[99:36], e.row_pixels);
            if (t[100] !== e.awaiting_key) report("awaiting_key", t[100], e.awaiting_key);
            if (t[101] !== e.tone_active) report("tone_active", t[101], e.tone_active);
        end
    endtask
endclass

module chip8_instruction_core_unit_tb;
    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;
    logic [1:0]   s_tuser = CMD_NONE;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;

    chip8_shadow shadow = new();
    bit          quiet = 0;
    int          stall_left = 0;
    int          sent = 0;

    chip8_instruction_core_unit u_dut (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) shadow.check(m_tdata);
        if (quiet) begin
            m_tready <= 1;
        end else if (stall_left > 0) begin
            m_tready <= 0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1;
            if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 4);
        end
    end

    task send(cmd_t cmd, logic [11:0] adr, logic [7:0] dat, logic [15:0] keys,
              logic [7:0] rnd, logic [4:0] row);
        int gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, row, rnd, keys, dat, adr};
        do @(posedge aclk); while (!s_tready);
        shadow.note(cmd, {row, rnd, keys, dat, adr});
        sent++;
    endtask

    function logic [15:0] any_keys();
        return ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
    endfunction

    task load(logic [11:0] adr, logic [7:0] dat);
        send(CMD_LOAD, adr, dat, 16'($urandom), 8'($urandom), 5'($urandom));
    endtask

    task run(logic [15:0] keys);
        if (shadow.bad_return()) load(shadow.pc + 12'd1, 8'hE0);
        send(CMD_RUN, 12'($urandom), 8'($urandom), keys, 8'($urandom), 5'($urandom));
    endtask

    task exec_op(logic [15:0] op, logic [15:0] keys);
        load(shadow.pc, op[15:8]);
        load(shadow.pc + 12'd1, op[7:0]);
        run(keys);
    endtask

    task read_row(logic [4:0] row);
        send(CMD_ROW, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), row);
    endtask

    function logic [15:0] pick_op();
        logic [15:0] r;
        logic [7:0]  fsel [10];
        fsel = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h00};
        r = 16'($urandom);
        case ($urandom_range(0, 17))
            0: return 16'h00E0;
            1: return 16'h00EE;
            2: return {4'h0, r[11:0]};
            3: return {4'h1, r[11:0]};
            4: return {4'h2, r[11:0]};
            5: return {4'h3, r[11:0]};
            6: return {4'h4, r[11:0]};
            7: return {4'h5, r[11:0]};
            8, 9: return {4'h6, r[11:0]};
            10: return {4'h7, r[11:0]};
            11, 12: return {4'h8, r[11:0]};
            13: return {4'h9, r[11:0]};
            14: return {4'hA, r[11:0]};
            15: return {4'hB + 4'(r[0]), r[11:0]};
            16: return {4'hD, r[11:0]};
            default: begin
                if (r[12]) return {4'hE, r[11:8], r[13] ? 8'h9E : 8'hA1};
                if (r[14]) return {4'hE, r[11:0]};
                fsel[9] = 8'($urandom);
                return {4'hF, r[11:8], fsel[$urandom_range(0, 9)]};
            end
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;

        // directed: corner values, register loads, an add, a sprite draw, key waits, call/return and BCD
        load(12'hFFF, 8'hFF);
        load(12'h000, 8'h00);
        send(CMD_NONE, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'h1F);
        exec_op(16'h6FFF, 16'h0);
        exec_op(16'h8FF4, 16'h0);
        exec_op(16'h603F, 16'h0);
        exec_op(16'h611E, 16'h0);
        exec_op(16'hA050, 16'h0);
        exec_op(16'hD015, 16'h0);
        read_row(5'd31);
        exec_op(16'hF00A, 16'h0);
        exec_op(16'hF30A, 16'h8000);
        exec_op(16'h2400, 16'h0);
        exec_op(16'h00EE, 16'h0);
        exec_op(16'hFF33, 16'h0);

        // hold off until the core has drained
        @(posedge aclk);
        s_tvalid <= 0;
        while (shadow.pending.size() != 0) @(posedge aclk);

        while (sent < 560) begin
            if (sent > 470) quiet = 1;
            case ($urandom_range(0, 19))
                0, 1: read_row(5'($urandom));
                2: load(12'($urandom), 8'($urandom));
                3: send(CMD_NONE, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                        5'($urandom));
                4, 5, 6: run(any_keys());
                default: exec_op(pick_op(), any_keys());
            endcase
        end
        @(posedge aclk);
        s_tvalid <= 0;
        while (shadow.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("covered %0d instruction cycles, %0d loads, %0d row reads", shadow.runs,
                 shadow.loads, shadow.rows);
        $display("sprite draws %0d, key waits %0d", shadow.draws, shadow.waits);
        if (shadow.errors == 0 && shadow.pending.size() == 0) begin
            $display("chip8_instruction_core_unit_tb: PASS");
        end else begin
            $display("chip8_instruction_core_unit_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("chip8_instruction_core_unit_tb: FAIL");
        $finish;
    end
endmodule

### filelist.f
rtl/c8_pkg.sv
rtl/c8_mem.sv
rtl/c8_fb.sv
rtl/c8_seq.sv
rtl/chip8_instruction_core_unit.sv
test/chip8_instruction_core_unit_tb.sv
